FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the fast-doubling Fibonacci RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define FDF_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("always-true check failed");

`define FDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define FDF_ASSERT_ALWAYS(lbl, clk, rstn, expr)

`define FDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/fdf_pkg.sv
// Widths and constants for the fast-doubling Fibonacci core.
// No dependencies; imported by fdf_mul64 and fast_doubling_fibonacci_core.
`timescale 1ns / 1ps

package fdf_pkg;

  localparam int unsigned IDX_W  = 7;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned HALF_W = VAL_W / 2;
  localparam int unsigned BIT_W  = $clog2(IDX_W);

  localparam logic [BIT_W-1:0] TOP_BIT        = BIT_W'(IDX_W - 1);
  localparam logic [IDX_W-1:0] LAST_EXACT_IDX = IDX_W'(93);

endpackage

FILE: rtl/core/fast_doubling_fibonacci_core.sv
// Fast-doubling Fibonacci core: F(n) mod 2^64 for a 7-bit index n.
// Uses fdf_pkg, fdf_mul64 and assert_macros.svh.
//
//   channel | ports                                   | role
//   in      | in_valid, in_ready, in_index_n          | index beat
//   out     | out_valid, out_ready, out_fib_value,    | result beat
//           | out_overflowed                          |
//
// Each index scans all 7 bits; a bit takes three 64-bit multiplies on the
// shared 32x32 multiplier plus an update state. A new index is accepted
// only once the result of the last one has been loaded into the out register.
// in_ready is high only in idle; a stalled out beat holds the core in its
// final state. Synchronous active-low reset clears control only.
`timescale 1ns / 1ps

module fast_doubling_fibonacci_core import fdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_index_n,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_fib_value,
  output logic             out_overflowed
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_EVEN_GO, S_EVEN_WAIT, S_SQA_GO, S_SQA_WAIT,
    S_SQB_GO, S_SQB_WAIT, S_UPDATE, S_DONE
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  n_r;
  logic [BIT_W-1:0]  bit_r;
  logic              ovf_r;
  logic [VAL_W-1:0]  fk_r;
  logic [VAL_W-1:0]  fk1_r;
  logic [VAL_W-1:0]  even_r;
  logic [VAL_W-1:0]  sqa_r;
  logic [VAL_W-1:0]  odd_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_fib_r;
  logic              out_ovf_r;

  logic              mul_start;
  logic [VAL_W-1:0]  mul_a;
  logic [VAL_W-1:0]  mul_b;
  logic              mul_busy;
  logic              mul_done;
  logic [VAL_W-1:0]  mul_prod;
  logic [VAL_W-1:0]  twice_diff;

  assign twice_diff = {fk1_r[VAL_W-2:0], 1'b0} - fk_r;
  assign mul_start  = (state_r == S_EVEN_GO) || (state_r == S_SQA_GO) ||
                      (state_r == S_SQB_GO);

  always_comb begin
    unique case (state_r)
      S_EVEN_GO: begin
        mul_a = fk_r;
        mul_b = twice_diff;
      end
      S_SQB_GO: begin
        mul_a = fk1_r;
        mul_b = fk1_r;
      end
      default: begin
        mul_a = fk_r;
        mul_b = fk_r;
      end
    endcase
  end

  fdf_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r     <= in_index_n;
            ovf_r   <= (in_index_n > LAST_EXACT_IDX);
            bit_r   <= TOP_BIT;
            fk_r    <= '0;
            fk1_r   <= VAL_W'(1);
            state_r <= S_EVEN_GO;
          end
        end
        S_EVEN_GO: state_r <= S_EVEN_WAIT;
        S_EVEN_WAIT: begin
          if (mul_done) begin
            even_r  <= mul_prod;
            state_r <= S_SQA_GO;
          end
        end
        S_SQA_GO: state_r <= S_SQA_WAIT;
        S_SQA_WAIT: begin
          if (mul_done) begin
            sqa_r   <= mul_prod;
            state_r <= S_SQB_GO;
          end
        end
        S_SQB_GO: state_r <= S_SQB_WAIT;
        S_SQB_WAIT: begin
          if (mul_done) begin
            odd_r   <= sqa_r + mul_prod;
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (n_r[bit_r]) begin
            fk_r  <= odd_r;
            fk1_r <= even_r + odd_r;
          end else begin
            fk_r  <= even_r;
            fk1_r <= odd_r;
          end
          if (bit_r == '0) begin
            state_r <= S_DONE;
          end else begin
            bit_r   <= bit_r - BIT_W'(1);
            state_r <= S_EVEN_GO;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_fib_r   <= fk_r;
            out_ovf_r   <= ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_fib_value  = out_fib_r;
  assign out_overflowed = out_ovf_r;

  `FDF_ASSERT_ALWAYS(a_idle_mul_quiet, clk, rst_n, !in_ready || !mul_busy)
  `FDF_ASSERT_ALWAYS(a_done_in_wait, clk, rst_n,
    !mul_done || state_r == S_EVEN_WAIT || state_r == S_SQA_WAIT ||
    state_r == S_SQB_WAIT)
  `FDF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready,
    state_r == S_EVEN_GO && bit_r == TOP_BIT)

endmodule

FILE: rtl/core/fdf_mul64.sv
// Sequential 64x64 multiplier keeping the low 64 product bits.
// One shared 32x32 multiplier over three partial products; uses fdf_pkg.
`timescale 1ns / 1ps

module fdf_mul64 import fdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] op_a,
  input  logic [VAL_W-1:0] op_b,
  output logic             busy,
  output logic             done,
  output logic [VAL_W-1:0] prod
);

  typedef enum logic [1:0] {PH_LL, PH_LH, PH_HL} phase_t;

  phase_t             phase_r;
  logic               busy_r;
  logic               done_r;
  logic [VAL_W-1:0]   a_r;
  logic [VAL_W-1:0]   b_r;
  logic [VAL_W-1:0]   acc_r;
  logic [HALF_W-1:0]  mul_x;
  logic [HALF_W-1:0]  mul_y;
  logic [VAL_W-1:0]   part;

  assign mul_x = (phase_r == PH_HL) ? a_r[VAL_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign mul_y = (phase_r == PH_LH) ? b_r[VAL_W-1:HALF_W] : b_r[HALF_W-1:0];
  assign part  = VAL_W'(mul_x) * VAL_W'(mul_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LL;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r     <= op_a;
        b_r     <= op_b;
        busy_r  <= 1'b1;
        phase_r <= PH_LL;
      end else if (busy_r) begin
        unique case (phase_r)
          PH_LL: begin
            acc_r   <= part;
            phase_r <= PH_LH;
          end
          PH_LH: begin
            acc_r[VAL_W-1:HALF_W] <= acc_r[VAL_W-1:HALF_W] + part[HALF_W-1:0];
            phase_r               <= PH_HL;
          end
          PH_HL: begin
            acc_r[VAL_W-1:HALF_W] <= acc_r[VAL_W-1:HALF_W] + part[HALF_W-1:0];
            busy_r                <= 1'b0;
            done_r                <= 1'b1;
            phase_r               <= PH_LL;
          end
          default: phase_r <= PH_LL;
        endcase
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule
